FILE: rtl/triggered_transition_capture_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the triggered transition capture block
// Concurrent assertion wrappers that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef TRIGGERED_TRANSITION_CAPTURE_TOP_MACROS_SVH
`define TRIGGERED_TRANSITION_CAPTURE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Generic form: explicit clock and active-low reset.
`define TTC_ASSERT_AT(lbl_, clk_, rst_n_, prop_, msg_) \
  lbl_: assert property (@(posedge clk_) disable iff (!rst_n_) prop_) else $error(msg_);
// Short form for modules that use the standard clk_i / rst_ni names.
`define TTC_ASSERT(lbl_, prop_, msg_) \
  `TTC_ASSERT_AT(lbl_, clk_i, rst_ni, prop_, msg_)
`else
`define TTC_ASSERT_AT(lbl_, clk_, rst_n_, prop_, msg_)
`define TTC_ASSERT(lbl_, prop_, msg_)
`endif

`endif

FILE: rtl/ttc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triggered transition capture package
// Shared types, codes and constants of the capture block.
// ----------------------------------------------------------------------------
package ttc_pkg;

  localparam int unsigned CapacityDefault = 512;
  localparam int unsigned UsPerMs         = 1000;
  localparam int unsigned TimeoutMsW      = 16;
  // 65535 ms expressed in microseconds fits in 26 bits.
  localparam int unsigned LimitW          = 26;
  localparam logic [TimeoutMsW-1:0] TimeoutMsReset = 16'd1000;
  localparam int unsigned PaddrW          = 3;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_WAIT_LOW  = 2'd1,
    PH_WAIT_HIGH = 2'd2,
    PH_READ      = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    EV_RECORD       = 2'd0,
    EV_TIMEOUT_LOW  = 2'd1,
    EV_TIMEOUT_HIGH = 2'd2,
    EV_TIMEOUT_READ = 2'd3
  } event_e;

  typedef enum logic {
    REG_TIMEOUT_MS = 1'b0
  } reg_idx_e;

  typedef struct packed {
    logic        kind;
    logic        trigger_level;
    logic [7:0]  bus_value;
    logic [31:0] now_us;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [7:0]  value;
    logic [31:0] duration_us;
    logic        last;
  } out_item_t;

  // Result handed from the capture core to the output register.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } core_res_t;

endpackage

FILE: rtl/ttc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triggered transition capture core
// Capture state and the per-item decision logic of the capture sequence.
// ----------------------------------------------------------------------------
`include "triggered_transition_capture_top_macros.svh"

module ttc_core #(
  parameter int unsigned Capacity = ttc_pkg::CapacityDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         fire_i,
  input  ttc_pkg::in_item_t            item_i,
  input  logic [ttc_pkg::LimitW-1:0]   limit_us_i,
  output ttc_pkg::core_res_t           res_o
);
  import ttc_pkg::*;

  localparam int unsigned CntW = $clog2(Capacity + 1);

  phase_e          phase_q, phase_d;
  logic [7:0]      held_q, held_d;
  logic [31:0]     run_start_q, run_start_d;
  logic [31:0]     wd_start_q, wd_start_d;
  logic [CntW-1:0] count_q, count_d;

  logic [31:0]     elapsed;
  logic            expired;
  logic            changed;
  logic [CntW-1:0] count_inc;
  logic            last_hit;

  assign elapsed   = item_i.now_us - wd_start_q;
  assign expired   = elapsed >= {{(32 - LimitW){1'b0}}, limit_us_i};
  assign changed   = item_i.bus_value != held_q;
  assign count_inc = count_q + CntW'(1);
  assign last_hit  = count_inc >= CntW'(Capacity);

  always_comb begin
    phase_d = phase_q;
    if (fire_i) begin
      if (item_i.kind) begin
        phase_d = PH_WAIT_LOW;
      end else begin
        case (phase_q)
          PH_WAIT_LOW: begin
            if (expired) phase_d = PH_IDLE;
            else if (!item_i.trigger_level) phase_d = PH_WAIT_HIGH;
          end
          PH_WAIT_HIGH: begin
            if (expired) phase_d = PH_IDLE;
            else if (item_i.trigger_level) phase_d = PH_READ;
          end
          PH_READ: begin
            if (expired) phase_d = PH_IDLE;
            else if (changed && last_hit) phase_d = PH_IDLE;
          end
          default: phase_d = phase_q;
        endcase
      end
    end
  end

  always_comb begin
    held_d      = held_q;
    run_start_d = run_start_q;
    wd_start_d  = wd_start_q;
    count_d     = count_q;
    res_o       = '0;
    if (fire_i) begin
      if (item_i.kind) begin
        count_d    = '0;
        held_d     = '0;
        wd_start_d = item_i.now_us;
      end else begin
        case (phase_q)
          PH_WAIT_LOW: begin
            if (expired) begin
              res_o.valid          = 1'b1;
              res_o.item.event_res = EV_TIMEOUT_LOW;
            end else if (!item_i.trigger_level) begin
              wd_start_d = item_i.now_us;
            end
          end
          PH_WAIT_HIGH: begin
            if (expired) begin
              res_o.valid          = 1'b1;
              res_o.item.event_res = EV_TIMEOUT_HIGH;
            end else if (item_i.trigger_level) begin
              run_start_d = item_i.now_us;
              held_d      = item_i.bus_value;
              wd_start_d  = item_i.now_us;
            end
          end
          PH_READ: begin
            if (expired) begin
              res_o.valid          = 1'b1;
              res_o.item.event_res = EV_TIMEOUT_READ;
            end else if (changed) begin
              res_o.valid            = 1'b1;
              res_o.item.event_res   = EV_RECORD;
              res_o.item.value       = held_q;
              res_o.item.duration_us = item_i.now_us - run_start_q;
              res_o.item.last        = last_hit;
              wd_start_d             = item_i.now_us;
              count_d                = count_inc;
              if (!last_hit) begin
                run_start_d = item_i.now_us;
                held_d      = item_i.bus_value;
              end
            end
          end
          default: res_o = '0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      held_q      <= '0;
      run_start_q <= '0;
      wd_start_q  <= '0;
      count_q     <= '0;
    end else begin
      phase_q     <= phase_d;
      held_q      <= held_d;
      run_start_q <= run_start_d;
      wd_start_q  <= wd_start_d;
      count_q     <= count_d;
    end
  end

  `TTC_ASSERT(a_arm_restarts, fire_i && item_i.kind |=> phase_q == PH_WAIT_LOW && count_q == '0, "arm did not restart the capture")
  `TTC_ASSERT(a_last_goes_idle, res_o.valid && res_o.item.last |=> phase_q == PH_IDLE, "capture not closed after the last record")
  `TTC_ASSERT(a_count_bounded, count_q <= CntW'(Capacity), "record count beyond capacity")
  `TTC_ASSERT(a_idle_silent, phase_q == PH_IDLE && !(fire_i && item_i.kind) |=> $stable(count_q), "count moved while idle")

endmodule

FILE: rtl/triggered_transition_capture_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triggered transition capture, top level
// Arms on a command, waits for a low-then-high trigger pulse and streams one
// record per run of an unchanged bus value, with a per-phase watchdog.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+--------------------------------
//   in      | input     | in_valid / stall   | kind, trigger, bus, now_us
//   out     | output    | out_valid / stall  | event, value, duration, last
//   cfg     | input     | APB write and read | watchdog ms at byte address 0
//
// One transaction is accepted every clock cycle when the output side keeps up.
// The input register feeds the capture core, whose decision logic updates the
// capture state and writes the output register in the same cycle, so a result
// is held first in the input register and then in the output register before
// it is presented.
// Reset is asynchronous and active low; it leaves the block idle with a
// 1000 ms watchdog. A stall on the output holds the result register, and the
// input stalls only while its register holds a transaction that cannot move.
//
`include "triggered_transition_capture_top_macros.svh"

module triggered_transition_capture_top #(
  parameter int unsigned Capacity = ttc_pkg::CapacityDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Sample and arm transactions.
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  ttc_pkg::in_item_t            in_item_i,
  // Record and timeout transactions.
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output ttc_pkg::out_item_t           out_item_o,
  // Register port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ttc_pkg::PaddrW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import ttc_pkg::*;

  // Register file: the watchdog interval is kept both in milliseconds, for
  // read-back, and pre-scaled to microseconds so the per-item compare needs
  // no multiplier.
  logic [TimeoutMsW-1:0] wd_ms_q;
  logic [LimitW-1:0]     limit_us_q;
  logic                  cfg_write;
  reg_idx_e              reg_idx;

  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_e'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      REG_TIMEOUT_MS: prdata = {{(32 - TimeoutMsW){1'b0}}, wd_ms_q};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wd_ms_q    <= TimeoutMsReset;
      limit_us_q <= LimitW'(TimeoutMsReset) * LimitW'(UsPerMs);
    end else if (cfg_write && reg_idx == REG_TIMEOUT_MS) begin
      wd_ms_q    <= pwdata[TimeoutMsW-1:0];
      limit_us_q <= LimitW'(pwdata[TimeoutMsW-1:0]) * LimitW'(UsPerMs);
    end
  end

  // Input register. The held transaction moves into the core whenever the
  // output register is empty or is being emptied in this cycle.
  logic      in_valid_q;
  in_item_t  in_q;
  logic      advance;
  logic      in_take;
  core_res_t core_res;

  assign advance    = in_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_item_i;
    end
  end

  ttc_core #(
    .Capacity(Capacity)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (advance),
    .item_i     (in_q),
    .limit_us_i (limit_us_q),
    .res_o      (core_res)
  );

  // Output register. A new result is loaded only when the previous one has
  // left or is leaving, which the advance condition already guarantees.
  logic      out_valid_q;
  out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && core_res.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && core_res.valid) begin
      out_q <= core_res.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `TTC_ASSERT(a_stall_only_when_full, in_stall_o |-> in_valid_q && out_valid_q && out_stall_i, "input stalled without a blocked transaction")
  `TTC_ASSERT(a_result_lands, advance && core_res.valid |=> out_valid_q, "core result was not captured")
  `TTC_ASSERT(a_held_result_kept, out_valid_q && out_stall_i |=> out_valid_q, "stalled result was dropped")
  `TTC_ASSERT(a_limit_tracks_ms, limit_us_q == LimitW'(wd_ms_q) * LimitW'(UsPerMs), "scaled watchdog limit out of step")

endmodule
